// ----- rtl/core/masked_byte_pattern_search_assert.svh -----
// ----------------------------------------------------------------------------
// masked_byte_pattern_search assertion macros
// shared concurrent checks, sampled on clk and held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH

// same-cycle implication
`define MBPS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/mbps_pkg.sv -----
// ----------------------------------------------------------------------------
// mbps_pkg
// types and register codes for the masked byte pattern search
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int POS_W       = 32;
    localparam int LEN_W       = 5;
    localparam int MASK_W      = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT_LIMIT    = 3'd4;

    localparam logic [POS_W-1:0] POS_MAX          = '1;
    localparam logic [POS_W-1:0] COUNT_LIMIT_INIT = 32'd1;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] pattern_high;
        logic [CFG_DATA_W-1:0] pattern_low;
        logic [MASK_W-1:0]     care_mask;
        logic [LEN_W-1:0]      pattern_length;
        logic [POS_W-1:0]      count_limit;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // window compare result for the byte being consumed
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] offset;
    } win_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/mbps_if.sv -----
// ----------------------------------------------------------------------------
// mbps channel interfaces
// valid/ready channels for configuration, input bytes and results
// ----------------------------------------------------------------------------
`default_nettype none

interface mbps_cfg_if;
    import mbps_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface mbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_out_if;
    import mbps_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] first_offset;
    logic [POS_W-1:0] match_count;

    modport source (output valid, output found, output first_offset,
                    output match_count, input ready);
    modport sink   (input valid, input found, input first_offset,
                    input match_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mbps_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mbps_cfg_regs
// configuration register file written through the cfg channel
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_cfg_regs (
    input  wire logic           clk,
    input  wire logic           rst_n,
    mbps_cfg_if.sink            cfg,
    output mbps_pkg::cfg_t      cfg_regs
);
    import mbps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // always ready for a write
    assign cfg.ready = 1'b1;
    assign cfg_regs  = cfg_reg;

    // register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_PATTERN_LOW:    cfg_next.pattern_low    = cfg.data;
                REG_PATTERN_HIGH:   cfg_next.pattern_high   = cfg.data;
                REG_CARE_MASK:      cfg_next.care_mask      = cfg.data[MASK_W-1:0];
                REG_PATTERN_LENGTH: cfg_next.pattern_length = cfg.data[LEN_W-1:0];
                REG_COUNT_LIMIT:    cfg_next.count_limit    = cfg.data[POS_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_low    <= '0;
            cfg_reg.pattern_high   <= '0;
            cfg_reg.care_mask      <= '0;
            cfg_reg.pattern_length <= '0;
            cfg_reg.count_limit    <= COUNT_LIMIT_INIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mbps_in_reg.sv -----
// ----------------------------------------------------------------------------
// mbps_in_reg
// input register holding one byte transfer ahead of the compare stage
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_in_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    mbps_in_if.sink             data_in,
    input  wire logic           advance,
    output logic                item_valid,
    output mbps_pkg::in_item_t  item
);
    import mbps_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;
    logic     take;

    // accept when empty or when the held byte moves on
    assign data_in.ready = !valid_reg || advance;
    assign take          = data_in.valid && data_in.ready;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (data_in.ready)
        begin
            valid_reg <= data_in.valid;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.data_byte <= data_in.data_byte;
            item_reg.last_byte <= data_in.last_byte;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/mbps_window.sv -----
// ----------------------------------------------------------------------------
// mbps_window
// byte shift window, region byte counter and masked pattern compare
// ----------------------------------------------------------------------------
`default_nettype none

`include "masked_byte_pattern_search_assert.svh"

module mbps_window #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  mbps_pkg::in_item_t   item,
    input  mbps_pkg::cfg_t       cfg_regs,
    output mbps_pkg::win_status_t status
);
    import mbps_pkg::*;

    localparam int AGE_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [7:0]       win_reg [MAX_PATTERN_BYTES];
    logic [7:0]       win_next [MAX_PATTERN_BYTES];
    logic [POS_W-1:0] bytes_seen_reg;
    logic [POS_W-1:0] bytes_seen_next;
    logic [2*CFG_DATA_W-1:0] pattern;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] age;
    logic             len_ok;
    logic             enough;
    logic             window_ok;

    assign pattern = {cfg_regs.pattern_high, cfg_regs.pattern_low};
    assign len     = cfg_regs.pattern_length;

    // window after shifting in the current byte, entry 0 newest
    always_comb
    begin
        for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--)
        begin
            win_next[i] = win_reg[i-1];
        end
        win_next[0] = item.data_byte;
    end

    // saturating region position
    assign bytes_seen_next = (bytes_seen_reg == POS_MAX) ? bytes_seen_reg
                                                         : bytes_seen_reg + 32'd1;

    // masked compare, pattern byte k against the byte len-1-k back
    always_comb
    begin
        window_ok = 1'b1;
        age       = '0;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++)
        begin
            age = len - LEN_W'(1) - LEN_W'(k);
            if ((LEN_W'(k) < len) && cfg_regs.care_mask[k] &&
                (win_next[age[AGE_W-1:0]] != pattern[8*k +: 8]))
            begin
                window_ok = 1'b0;
            end
        end
    end

    assign len_ok = (len != '0) && (32'(len) <= 32'(MAX_PATTERN_BYTES));
    assign enough = bytes_seen_next >= 32'(len);

    assign status.hit    = len_ok && enough && window_ok;
    assign status.offset = bytes_seen_next - 32'(len);

    // window and position, cleared at end of region
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
            begin
                win_reg[i] <= '0;
            end
            bytes_seen_reg <= '0;
        end
        else if (advance)
        begin
            if (item.last_byte)
            begin
                for (int i = 0; i < MAX_PATTERN_BYTES; i++)
                begin
                    win_reg[i] <= '0;
                end
                bytes_seen_reg <= '0;
            end
            else
            begin
                for (int i = 0; i < MAX_PATTERN_BYTES; i++)
                begin
                    win_reg[i] <= win_next[i];
                end
                bytes_seen_reg <= bytes_seen_next;
            end
        end
    end

    // region restarts at position zero
    `MBPS_ASSERT_NEXT(a_pos_clear, advance && item.last_byte, bytes_seen_reg == '0,
        "position not cleared after last byte")

endmodule

`default_nettype wire

// ----- rtl/core/mbps_result.sv -----
// ----------------------------------------------------------------------------
// mbps_result
// match counting, first offset capture and the result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "masked_byte_pattern_search_assert.svh"

module mbps_result (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic             last_byte,
    input  mbps_pkg::win_status_t status,
    input  wire logic [31:0]      count_limit,
    output logic                  out_free,
    mbps_out_if.source            result
);
    import mbps_pkg::*;

    logic             seen_reg;
    logic [POS_W-1:0] first_reg;
    logic [POS_W-1:0] matches_reg;
    logic             seen_next;
    logic [POS_W-1:0] first_next;
    logic [POS_W-1:0] matches_next;
    logic             counted;

    logic             out_valid_reg;
    logic             found_reg;
    logic [POS_W-1:0] first_out_reg;
    logic [POS_W-1:0] count_out_reg;

    // result register can take a new result this cycle
    assign out_free = !out_valid_reg || result.ready;

    // count limit; a limit of zero never counts
    assign counted      = status.hit && (matches_reg < count_limit);
    assign seen_next    = seen_reg || counted;
    assign first_next   = (counted && !seen_reg) ? status.offset : first_reg;
    assign matches_next = matches_reg + 32'(counted);

    // region state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= 1'b0;
            first_reg   <= '0;
            matches_reg <= '0;
        end
        else if (advance)
        begin
            if (last_byte)
            begin
                seen_reg    <= 1'b0;
                first_reg   <= '0;
                matches_reg <= '0;
            end
            else
            begin
                seen_reg    <= seen_next;
                first_reg   <= first_next;
                matches_reg <= matches_next;
            end
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && last_byte)
        begin
            found_reg     <= seen_next;
            first_out_reg <= seen_next ? first_next : '0;
            count_out_reg <= matches_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.found        = found_reg;
    assign result.first_offset = first_out_reg;
    assign result.match_count  = count_out_reg;

    `MBPS_ASSERT_IMPLY(a_count_needs_seen, !seen_reg, matches_reg == '0,
        "matches counted without a recorded first match")
    `MBPS_ASSERT_NEXT(a_seen_after_count, advance && !last_byte && counted, seen_reg,
        "counted match did not set match seen")
    `MBPS_ASSERT_IMPLY(a_empty_result, out_valid_reg && !found_reg,
        first_out_reg == '0 && count_out_reg == '0,
        "result without match carries offset or count")

endmodule

`default_nettype wire

// ----- rtl/core/masked_byte_pattern_search.sv -----
// Path: a last byte is held in the input register, which feeds the compare,
// and the result register captures the region result and presents it.
// Throughput: 1 byte per cycle; a last byte waits only while the result register
// holds a result that has not been transferred out.
// Reset: rst_n clears window, counters and valid flags at once; payloads hold.
// ----------------------------------------------------------------------------
// masked_byte_pattern_search
// streaming search of a byte region for a masked pattern of up to 16 bytes
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_search #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mbps_cfg_if.sink   cfg,
    mbps_in_if.sink    data_in,
    mbps_out_if.source result
);
    import mbps_pkg::*;

    cfg_t        cfg_regs;
    in_item_t    item;
    logic        item_valid;
    logic        advance;
    logic        out_free;
    win_status_t status;

    // a byte moves on unless it ends a region and the result slot is full
    assign advance = item_valid && (!item.last_byte || out_free);

    mbps_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_regs (cfg_regs)
    );

    mbps_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_in    (data_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mbps_window #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (item),
        .cfg_regs (cfg_regs),
        .status   (status)
    );

    mbps_result u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .last_byte   (item.last_byte),
        .status      (status),
        .count_limit (cfg_regs.count_limit),
        .out_free    (out_free),
        .result      (result)
    );

endmodule

`default_nettype wire
